// File: design/wccs_pkg.sv
package wccs_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 12;
    localparam int SCALE_BITS  = 32;
    localparam int SCALE_FRAC  = 16;
    localparam int ROW_W       = 13;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_STOPS   = 7;
    localparam int CNT_W       = 3;
    localparam int POS_W       = 32;
    localparam int CLS_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = VALUE_BITS + SCALE_BITS;
    localparam int ROUND_SHIFT = FRAC_BITS + SCALE_FRAC;
    localparam int RND_W       = PROD_W - ROUND_SHIFT + 1;

    // 1.0 in the value format
    localparam logic signed [VALUE_BITS-1:0] VALUE_ONE = VALUE_BITS'(1 << FRAC_BITS);

    // color classes; the selected variant of each class but blank is the base plus one
    localparam logic [CLS_W-1:0] CLS_BLANK  = 4'd0;
    localparam logic [CLS_W-1:0] CLS_BG     = 4'd1;
    localparam logic [CLS_W-1:0] CLS_SAMPLE = 4'd3;
    localparam logic [CLS_W-1:0] CLS_RMS    = 4'd5;
    localparam logic [CLS_W-1:0] CLS_CLIP   = 4'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MAX      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_CLIPPING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_FIRST     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_LAST      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEVEL    = 3'd7;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] col_min;
        logic signed [VALUE_BITS-1:0] col_max;
        logic [VALUE_BITS-2:0]        col_rms;
        logic signed [POS_W-1:0]      pixel_position;
    } t_col_in;

    typedef struct packed {
        logic [CLS_W-1:0] color_class;
        logic [ROW_W-1:0] end_row;
        logic             last_stop;
    } t_stop;

    typedef struct packed {
        t_stop [MAX_STOPS-1:0] stop;
        logic [CNT_W-1:0]      count;
    } t_stop_list;

    typedef struct packed {
        logic [ROW_W-1:0] row_max;
        logic [ROW_W-1:0] row_pos;
        logic [ROW_W-1:0] row_neg;
        logic [ROW_W-1:0] row_min;
        logic [ROW_W-1:0] row_gmin;
        logic             sel;
        logic             clip;
    } t_rows;

    // positive distance below the view top, zero when the value is at or above it
    function automatic logic [VALUE_BITS-1:0] f_span(
        input logic signed [VALUE_BITS:0] top,
        input logic signed [VALUE_BITS:0] v
    );
        logic signed [VALUE_BITS+1:0] d;
        d = {top[VALUE_BITS], top} - {v[VALUE_BITS], v};
        return (d > 0) ? d[VALUE_BITS-1:0] : '0;
    endfunction

    // round half up and saturate to the column height
    function automatic logic [ROW_W-1:0] f_row(
        input logic [PROD_W-1:0] p,
        input logic [ROW_W-1:0]  h
    );
        logic [RND_W-1:0] r;
        r = {1'b0, p[PROD_W-1:ROUND_SHIFT]} + RND_W'(p[ROUND_SHIFT-1]);
        return (r > RND_W'(h)) ? h : r[ROW_W-1:0];
    endfunction

endpackage

// File: design/waveform_column_color_stops_core.sv
// Waveform column color stops.
// A column (min, max, rms, pixel position) is transferred in on i_col at a
// clock edge where start is high and busy is low. The column's color runs
// leave one stop per cycle on o_stop, each valid for the single cycle in
// which o_strobe is high; last_stop marks the final stop of the column.
// The receiver has no way to stall the output.
// Columns pass a span-multiply stage and a round/clamp stage before the
// stop list is built; the stop serializer sets the rate: a column producing
// N stops (1 to 7) sends them back to back, and the serializer takes the
// next column's list while it sends the last stop of the current one, so
// clipped columns pass at up to one per cycle when no longer column holds the
// serializer. A zero height column produces no stops and does not load it.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// the user must write it only while the block is idle; the block does not enforce this.
// Reset (synchronous, active low) clears the pipeline and loads the default
// view of -1.0 to 1.0 over 256 rows, clipping shown at 1.0, no selection.
module waveform_column_color_stops_core
    import wccs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_col_in               i_col,
    output t_stop                 o_stop,
    output logic                  o_strobe,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic signed [VALUE_BITS-1:0] r_view_max;
    logic signed [VALUE_BITS-1:0] r_view_min;
    logic [SCALE_BITS-1:0]        r_row_scale;
    logic [ROW_W-1:0]             r_height;
    logic                         r_show_clipping;
    logic signed [POS_W-1:0]      r_sel_first;
    logic signed [POS_W-1:0]      r_sel_last;
    logic [VALUE_BITS-2:0]        r_clip_level;

    // pipeline
    logic             r_s1_valid;
    t_col_in          r_s1_item;
    logic             r_s2_valid;
    logic [PROD_W-1:0] r_p_max, r_p_pos, r_p_neg, r_p_min, r_p_bot;
    logic             r_s2_sel;
    logic             r_s2_clip;
    logic             r_s3_valid;
    t_rows            r_rows;

    logic [ROW_W-1:0]          w_height;
    logic signed [VALUE_BITS:0] w_top, w_min, w_max, w_rms, w_bot, w_clip;
    logic                      w_sel, w_clip_hit;
    logic [ROW_W-1:0]          w_row_bot;
    t_stop_list                w_list;
    logic                      w_emit_ready, w_list_empty;
    logic                      w_free1, w_free2, w_free3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_max      <= VALUE_ONE;
            r_view_min      <= -VALUE_ONE;
            r_row_scale     <= 32'd8355840;
            r_height        <= 13'd256;
            r_show_clipping <= 1'b1;
            r_sel_first     <= '1;
            r_sel_last      <= '1;
            r_clip_level    <= (VALUE_BITS-1)'(VALUE_ONE);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VIEW_MAX:      r_view_max      <= i_cfg_data[VALUE_BITS-1:0];
                CFG_VIEW_MIN:      r_view_min      <= i_cfg_data[VALUE_BITS-1:0];
                CFG_ROW_SCALE:     r_row_scale     <= i_cfg_data[SCALE_BITS-1:0];
                CFG_HEIGHT:        r_height        <= i_cfg_data[ROW_W-1:0];
                CFG_SHOW_CLIPPING: r_show_clipping <= i_cfg_data[0];
                CFG_SEL_FIRST:     r_sel_first     <= i_cfg_data[POS_W-1:0];
                CFG_SEL_LAST:      r_sel_last      <= i_cfg_data[POS_W-1:0];
                CFG_CLIP_LEVEL:    r_clip_level    <= i_cfg_data[VALUE_BITS-2:0];
                default:           r_clip_level    <= r_clip_level;
            endcase
        end
    end

    assign w_height = (r_height > ROW_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : r_height;

    // stall chain: a stage frees when the one after it takes its item
    assign w_list_empty = (w_list.count == '0);
    assign w_free3 = !r_s3_valid || w_emit_ready || w_list_empty;
    assign w_free2 = !r_s2_valid || w_free3;
    assign w_free1 = !r_s1_valid || w_free2;
    assign busy    = !w_free1;

    // stage 1 -> 2: spans below the view top, multiplied by the row scale
    assign w_top  = {r_view_max[VALUE_BITS-1], r_view_max};
    assign w_bot  = {r_view_min[VALUE_BITS-1], r_view_min};
    assign w_min  = {r_s1_item.col_min[VALUE_BITS-1], r_s1_item.col_min};
    assign w_max  = {r_s1_item.col_max[VALUE_BITS-1], r_s1_item.col_max};
    assign w_rms  = {2'b00, r_s1_item.col_rms};
    assign w_clip = {2'b00, r_clip_level};

    assign w_sel = (r_s1_item.pixel_position >= r_sel_first)
                && (r_s1_item.pixel_position < r_sel_last);
    assign w_clip_hit = r_show_clipping && ((w_min <= -w_clip) || (w_max >= w_clip));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_free1) begin
                r_s1_valid <= start;
            end
            if (w_free2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_free3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    assign w_row_bot = f_row(r_p_bot, w_height);

    always_ff @(posedge i_clk) begin
        if (start && w_free1) begin
            r_s1_item <= i_col;
        end
        if (r_s1_valid && w_free2) begin
            r_p_max   <= PROD_W'(f_span(w_top, w_max)) * PROD_W'(r_row_scale);
            r_p_pos   <= PROD_W'(f_span(w_top, w_rms)) * PROD_W'(r_row_scale);
            r_p_neg   <= PROD_W'(f_span(w_top, -w_rms)) * PROD_W'(r_row_scale);
            r_p_min   <= PROD_W'(f_span(w_top, w_min)) * PROD_W'(r_row_scale);
            r_p_bot   <= PROD_W'(f_span(w_top, w_bot)) * PROD_W'(r_row_scale);
            r_s2_sel  <= w_sel;
            r_s2_clip <= w_clip_hit;
        end
        if (r_s2_valid && w_free3) begin
            r_rows.row_max  <= f_row(r_p_max, w_height);
            r_rows.row_pos  <= f_row(r_p_pos, w_height);
            r_rows.row_neg  <= f_row(r_p_neg, w_height);
            r_rows.row_min  <= f_row(r_p_min, w_height);
            // bottom limit sits one row below the view bottom, held to the height
            r_rows.row_gmin <= (w_row_bot == w_height) ? w_height : w_row_bot + 1'b1;
            r_rows.sel      <= r_s2_sel;
            r_rows.clip     <= r_s2_clip;
        end
    end

    wccs_stop_list u_list (
        .i_rows      (r_rows),
        .i_height    (w_height),
        .i_top_blank (r_view_max > VALUE_ONE),
        .o_list      (w_list)
    );

    wccs_stop_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_s3_valid && !w_list_empty),
        .i_list   (w_list),
        .o_ready  (w_emit_ready),
        .o_stop   (o_stop),
        .o_strobe (o_strobe)
    );

endmodule

// File: design/wccs_stop_list.sv
module wccs_stop_list
    import wccs_pkg::*;
(
    input  t_rows            i_rows,
    input  logic [ROW_W-1:0] i_height,
    input  logic             i_top_blank,
    output t_stop_list       o_list
);

    logic [CLS_W-1:0] w_sel;
    logic [CNT_W-1:0] w_cnt;
    logic             w_done;

    assign w_sel = CLS_W'(i_rows.sel);

    always_comb begin
        o_list = '0;
        w_cnt  = '0;
        w_done = 1'b0;
        if (i_height == '0) begin
            w_done = 1'b1;
        end else if (i_rows.clip) begin
            o_list.stop[w_cnt] = '{CLS_CLIP + w_sel, i_height, 1'b0};
            w_cnt  = w_cnt + 1'b1;
            w_done = 1'b1;
        end
        if (!w_done) begin
            if (i_top_blank) begin
                // top of the view maps to row zero, so the blank run is empty
                o_list.stop[w_cnt] = '{CLS_BLANK, '0, 1'b0};
                w_cnt = w_cnt + 1'b1;
            end
            if (i_rows.row_max != '0) begin
                o_list.stop[w_cnt] = '{CLS_BG + w_sel, i_rows.row_max, 1'b0};
                w_cnt = w_cnt + 1'b1;
            end
            if (i_rows.row_max >= i_height) begin
                w_done = 1'b1;
            end
        end
        if (!w_done) begin
            if (i_rows.row_max < i_rows.row_pos) begin
                o_list.stop[w_cnt] = '{CLS_SAMPLE + w_sel, i_rows.row_pos, 1'b0};
                w_cnt = w_cnt + 1'b1;
            end
            if (i_rows.row_pos >= i_height) begin
                w_done = 1'b1;
            end
        end
        if (!w_done) begin
            if (i_rows.row_pos < i_rows.row_neg) begin
                o_list.stop[w_cnt] = '{CLS_RMS + w_sel, i_rows.row_neg, 1'b0};
                w_cnt = w_cnt + 1'b1;
            end
            if (i_rows.row_neg >= i_height) begin
                w_done = 1'b1;
            end
        end
        if (!w_done) begin
            // lower sample run goes out even when it paints nothing
            o_list.stop[w_cnt] = '{CLS_SAMPLE + w_sel, i_rows.row_min, 1'b0};
            w_cnt = w_cnt + 1'b1;
            if (i_rows.row_min < i_rows.row_gmin) begin
                o_list.stop[w_cnt] = '{CLS_BG + w_sel, i_rows.row_gmin, 1'b0};
                w_cnt = w_cnt + 1'b1;
            end
            if (i_rows.row_gmin < i_height) begin
                o_list.stop[w_cnt] = '{CLS_BLANK, i_height, 1'b0};
                w_cnt = w_cnt + 1'b1;
            end
        end
        o_list.count = w_cnt;
    end

endmodule

// File: design/wccs_stop_emit.sv
module wccs_stop_emit
    import wccs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_stop_list i_list,
    output logic       o_ready,
    output t_stop      o_stop,
    output logic       o_strobe
);

    logic             r_active;
    logic [CNT_W-1:0] r_idx;
    logic             r_strobe;
    t_stop_list       r_list;
    t_stop            r_out;
    logic             w_last;

    assign w_last   = (r_idx == CNT_W'(r_list.count - 1'b1));
    assign o_ready  = !r_active || w_last;
    assign o_stop   = r_out;
    assign o_strobe = r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_ready) begin
                r_active <= i_load;
                r_idx    <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_list <= i_list;
        end
        if (r_active) begin
            r_out <= '{r_list.stop[r_idx].color_class, r_list.stop[r_idx].end_row, w_last};
        end
    end

endmodule

// File: tb/tb_waveform_column_color_stops_core.sv
module tb_waveform_column_color_stops_core;
    import wccs_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 45;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_col_in               i_col;
    t_stop                 o_stop;
    logic                  o_strobe;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    waveform_column_color_stops_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_col       (i_col),
        .o_stop      (o_stop),
        .o_strobe    (o_strobe),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the view registers
    logic signed [VALUE_BITS-1:0] view_top;
    logic signed [VALUE_BITS-1:0] view_bottom;
    logic [SCALE_BITS-1:0]        rows_per_unit;
    logic [ROW_W-1:0]             col_height;
    logic                         clip_shown;
    logic signed [POS_W-1:0]      sel_first_pos;
    logic signed [POS_W-1:0]      sel_end_pos;
    logic [VALUE_BITS-2:0]        clip_mag;

    t_stop pending_stops[$];
    t_stop want;
    int    mismatch_count = 0;
    int    burst_left = 0;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_val;
        t_col_in              col;
        bit                   typed;
        t_stop                typed_stop;
    } t_plan_row;

    t_plan_row plan[$];

    function automatic t_stop mk_stop(logic [CLS_W-1:0] cls, int row_end);
        t_stop s;
        s.color_class = cls;
        s.end_row     = ROW_W'(row_end);
        s.last_stop   = 1'b0;
        return s;
    endfunction

    // map a value to its row: round half up, clamp to 0..h
    function automatic int row_of(int top, int v, int h);
        int                d;
        longint unsigned   p;
        longint unsigned   r;
        d = top - v;
        if (d <= 0)
            return 0;
        p = longint'(d) * longint'(rows_per_unit);
        r = (p >> 28) + ((p >> 27) & 64'd1);
        if (r > longint'(h))
            return h;
        return int'(r);
    endfunction

    function automatic void paint_column(t_col_in c);
        int               vmin, vmax, rms, top, bot, clip, h;
        int               gmax, gmin, rmax, rpos, rneg, rmin;
        logic [CLS_W-1:0] sv;
        t_stop            run[$];
        vmin = int'($signed(c.col_min));
        vmax = int'($signed(c.col_max));
        rms  = int'(c.col_rms);
        top  = int'(view_top);
        bot  = int'(view_bottom);
        clip = int'(clip_mag);
        h    = int'(col_height);
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        if (h == 0)
            return;
        sv = ($signed(c.pixel_position) >= sel_first_pos &&
              $signed(c.pixel_position) < sel_end_pos) ? 4'd1 : 4'd0;
        if (clip_shown && (vmin <= -clip || vmax >= clip)) begin
            run.push_back(mk_stop(CLS_CLIP + sv, h));
        end else begin
            gmax = row_of(top, top, h);
            gmin = row_of(top, bot, h) + 1;
            if (gmin > h)
                gmin = h;
            if (top > int'(VALUE_ONE))
                run.push_back(mk_stop(CLS_BLANK, gmax));
            rmax = row_of(top, vmax, h);
            if (rmax > 0)
                run.push_back(mk_stop(CLS_BG + sv, rmax));
            // stop as soon as a run reaches the bottom
            if (rmax < h) begin
                rpos = row_of(top, rms, h);
                if (rmax < rpos)
                    run.push_back(mk_stop(CLS_SAMPLE + sv, rpos));
                if (rpos < h) begin
                    rneg = row_of(top, -rms, h);
                    if (rpos < rneg)
                        run.push_back(mk_stop(CLS_RMS + sv, rneg));
                    if (rneg < h) begin
                        rmin = row_of(top, vmin, h);
                        run.push_back(mk_stop(CLS_SAMPLE + sv, rmin));
                        if (rmin < gmin)
                            run.push_back(mk_stop(CLS_BG + sv, gmin));
                        if (gmin < h)
                            run.push_back(mk_stop(CLS_BLANK, h));
                    end
                end
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last_stop = 1'b1;
        foreach (run[i])
            pending_stops.push_back(run[i]);
    endfunction

    function automatic logic [31:0] fit_scale(int vmax, int vmin, int h);
        longint q;
        if (vmax <= vmin || h < 1)
            return 32'h0001_0000;
        q = (longint'(h - 1) << 28) / longint'(vmax - vmin);
        if (q > 64'h0000_0000_FFFF_FFFF)
            return 32'hFFFF_FFFF;
        return q[31:0];
    endfunction

    function automatic t_col_in draw_column();
        t_col_in c;
        int      lo, hi, mx, mn, lim;
        lo = int'(view_bottom);
        hi = int'(view_top);
        if (lo > hi) begin
            lo = int'(view_top);
            hi = int'(view_bottom);
        end
        if ($urandom_range(0, 4) == 0) begin
            c.col_min        = 16'($urandom);
            c.col_max        = 16'($urandom);
            c.col_rms        = 15'($urandom);
            c.pixel_position = $urandom;
            return c;
        end
        mx  = lo + int'($urandom_range(0, hi - lo));
        mn  = lo + int'($urandom_range(0, mx - lo));
        lim = (mx > -mn) ? mx : -mn;
        if (lim < 0)
            lim = 0;
        if (lim > 32767)
            lim = 32767;
        c.col_max = 16'(mx);
        c.col_min = 16'(mn);
        c.col_rms = 15'($urandom_range(0, lim));
        c.pixel_position = ($urandom_range(0, 4) == 0) ? $urandom
                                                        : 32'(int'($urandom_range(0, 96)) - 16);
        return c;
    endfunction

    function automatic void plan_col(int mn, int mx, int rms, int pos, bit typed,
                                     logic [CLS_W-1:0] cls, int row_end);
        t_plan_row r;
        r.is_reg               = 1'b0;
        r.reg_idx              = '0;
        r.reg_val              = '0;
        r.col.col_min          = 16'(mn);
        r.col.col_max          = 16'(mx);
        r.col.col_rms          = 15'(rms);
        r.col.pixel_position   = 32'(pos);
        r.typed                = typed;
        r.typed_stop           = mk_stop(cls, row_end);
        r.typed_stop.last_stop = 1'b1;
        plan.push_back(r);
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, int val);
        t_plan_row r;
        r.is_reg     = 1'b1;
        r.reg_idx    = idx;
        r.reg_val    = 32'(val);
        r.col        = '0;
        r.typed      = 1'b0;
        r.typed_stop = '0;
        plan.push_back(r);
    endfunction

    // hold start until the transfer, then draw the gap before the next column
    task automatic send_column(t_col_in c, bit typed, t_stop typed_stop);
        int gap;
        start <= 1'b1;
        i_col <= c;
        do @(posedge i_clk); while (busy);
        if (typed)
            pending_stops.push_back(typed_stop);
        else
            paint_column(c);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(4, 20);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 13);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_stops.size() != 0);
        // zero height columns leave nothing behind to wait on
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_VIEW_MAX:      view_top      = val[VALUE_BITS-1:0];
            CFG_VIEW_MIN:      view_bottom   = val[VALUE_BITS-1:0];
            CFG_ROW_SCALE:     rows_per_unit = val;
            CFG_HEIGHT:        col_height    = val[ROW_W-1:0];
            CFG_SHOW_CLIPPING: clip_shown    = val[0];
            CFG_SEL_FIRST:     sel_first_pos = val;
            CFG_SEL_LAST:      sel_end_pos   = val;
            CFG_CLIP_LEVEL:    clip_mag      = val[VALUE_BITS-2:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_setting(int vmax, int vmin, logic [31:0] scale, int h, bit shw,
                                 int sf, int sl, int clip);
        wait_idle();
        write_reg(CFG_VIEW_MAX, 32'(vmax));
        write_reg(CFG_VIEW_MIN, 32'(vmin));
        write_reg(CFG_ROW_SCALE, scale);
        write_reg(CFG_HEIGHT, 32'(h));
        write_reg(CFG_SHOW_CLIPPING, 32'(shw));
        write_reg(CFG_SEL_FIRST, 32'(sf));
        write_reg(CFG_SEL_LAST, 32'(sl));
        write_reg(CFG_CLIP_LEVEL, 32'(clip));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_stops.size() == 0) begin
                $error("stop with none expected: color_class %0d end_row %0d last_stop %0d",
                       o_stop.color_class, o_stop.end_row, o_stop.last_stop);
                mismatch_count++;
            end else begin
                want = pending_stops.pop_front();
                if (o_stop.color_class !== want.color_class) begin
                    $error("color_class: expected %0d, actual %0d",
                           want.color_class, o_stop.color_class);
                    mismatch_count++;
                end
                if (o_stop.end_row !== want.end_row) begin
                    $error("end_row: expected %0d, actual %0d", want.end_row, o_stop.end_row);
                    mismatch_count++;
                end
                if (o_stop.last_stop !== want.last_stop) begin
                    $error("last_stop: expected %0d, actual %0d",
                           want.last_stop, o_stop.last_stop);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int          ph, vmax, vmin, hh, sf, sl, cl;
        logic [31:0] sc;
        bit          shw;

        view_top      = 16'sd4096;
        view_bottom   = -16'sd4096;
        rows_per_unit = 32'd8355840;
        col_height    = 13'd256;
        clip_shown    = 1'b1;
        sel_first_pos = -32'sd1;
        sel_end_pos   = -32'sd1;
        clip_mag      = 15'd4096;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_col       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed columns, starting from the reset view
        plan_col(0, 0, 0, 0, 0, CLS_BLANK, 0);
        plan_col(-100, 4096, 0, 3, 1, CLS_CLIP, 256);
        plan_col(-4096, 100, 0, 3, 1, CLS_CLIP, 256);
        plan_col(-32768, 32767, 32767, 32'h7FFF_FFFF, 1, CLS_CLIP, 256);
        plan_col(-4095, 4095, 4095, 32'h8000_0000, 0, CLS_BLANK, 0);
        plan_col(100, -100, 0, -1, 0, CLS_BLANK, 0);
        plan_col(0, 0, 32767, 0, 0, CLS_BLANK, 0);
        plan_col(-2000, 3000, 1500, 7, 0, CLS_BLANK, 0);
        plan_reg(CFG_SHOW_CLIPPING, 0);
        plan_col(-32768, 32767, 32767, -1, 0, CLS_BLANK, 0);
        plan_reg(CFG_CLIP_LEVEL, 0);
        plan_reg(CFG_SHOW_CLIPPING, 1);
        plan_col(0, 0, 0, 0, 1, CLS_CLIP, 256);
        plan_reg(CFG_SEL_FIRST, -5);
        plan_reg(CFG_SEL_LAST, 10);
        plan_col(0, 0, 0, -5, 1, CLS_CLIP + 4'd1, 256);
        plan_col(0, 0, 0, 10, 1, CLS_CLIP, 256);
        plan_reg(CFG_CLIP_LEVEL, 32767);
        plan_reg(CFG_VIEW_MAX, 8192);
        plan_col(-1000, 1000, 500, 0, 0, CLS_BLANK, 0);
        plan_reg(CFG_HEIGHT, 0);
        plan_col(0, 0, 0, 0, 0, CLS_BLANK, 0);
        plan_reg(CFG_HEIGHT, 8191);
        plan_col(-3000, 2000, 1000, 9, 0, CLS_BLANK, 0);
        plan_reg(CFG_ROW_SCALE, 32'hFFFF_FFFF);
        plan_col(-32000, -32000, 0, 20, 0, CLS_BLANK, 0);
        plan_reg(CFG_VIEW_MIN, -32768);
        plan_col(1, 2, 3, 4, 0, CLS_BLANK, 0);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_column(plan[i].col, plan[i].typed, plan[i].typed_stop);
            end
        end

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_setting(4096, -4096, fit_scale(4096, -4096, 256), 256, 1,
                                 16, 40, 4096);
                1: write_setting(8192, -8192, fit_scale(8192, -8192, 100), 100, 1,
                                 -10, 5, 32767);
                2: write_setting(2048, -2048, fit_scale(2048, -2048, 4096), 4096, 0,
                                 32'h8000_0000, 32'h7FFF_FFFF, 2048);
                3: write_setting(32767, -32768, 32'hFFFF_FFFF, 8191, 0, 0, 0, 32767);
                4: write_setting(-32768, 32767, 32'h0, 16, 1, 20, 10, 1);
                default: begin
                    vmax = $urandom_range(0, 12288);
                    vmin = vmax - int'($urandom_range(1, 16384));
                    hh   = $urandom_range(1, 600);
                    sc   = ($urandom_range(0, 3) == 0) ? $urandom : fit_scale(vmax, vmin, hh);
                    shw  = $urandom_range(0, 1);
                    sf   = int'($urandom_range(0, 40)) - 10;
                    sl   = sf + int'($urandom_range(0, 50));
                    cl   = $urandom_range(1, 32767);
                    write_setting(vmax, vmin, sc, hh, shw, sf, sl, cl);
                end
            endcase
            repeat (PHASE_ITEMS) send_column(draw_column(), 1'b0, '0);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
